>>> src/sos_pkg.sv
// Shared types and constants of the spiral order scanner.
package sos_pkg;

	// Element width and configuration register width
	localparam int VAL_W      = 32;
	localparam int CFG_DATA_W = 4;
	localparam int CFG_IDX_W  = 2;

	// Clamped sizes stay below 16, so these widths cover every parameter value
	localparam int DIM_W   = 5;
	localparam int COORD_W = 4;
	localparam int REM_W   = 8;
	localparam int LIN_W   = COORD_W + DIM_W;

	// Register indexes and reset values
	localparam logic [CFG_IDX_W-1:0]  CFG_ROW_COUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0]  CFG_COLUMN_COUNT = 2'd1;
	localparam logic [CFG_DATA_W-1:0] CFG_DIM_RESET    = 4'd8;

	typedef enum logic [1:0] {
		DIR_RIGHT,
		DIR_DOWN,
		DIR_LEFT,
		DIR_UP
	} dir_t;

	typedef enum logic {
		WK_IDLE,
		WK_RUN
	} walk_state_t;

	// One loaded matrix waiting for emission
	typedef struct packed {
		logic             bank;
		logic [DIM_W-1:0] rows;
		logic [DIM_W-1:0] cols;
	} job_t;

	// Back end hands a store bank back to the front end
	typedef struct packed {
		logic valid;
		logic bank;
	} release_t;

	// Zero reads as one, values above the limit saturate
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v,
			input int limit);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > 32'(limit)) begin
			r = DIM_W'(limit);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

endpackage

>>> src/sos_ifs.sv
// Channel interfaces of the spiral order scanner.
interface sos_item_if;
	logic                               valid;
	logic                               ready;
	logic signed [sos_pkg::VAL_W-1:0]   element_value;

	modport source(output valid, output element_value, input ready);
	modport sink(input valid, input element_value, output ready);
endinterface

interface sos_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [sos_pkg::VAL_W-1:0]   out_value;
	logic                               out_last;

	modport source(output valid, output out_value, output out_last, input ready);
	modport sink(input valid, input out_value, input out_last, output ready);
endinterface

interface sos_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [sos_pkg::CFG_IDX_W-1:0]       index;
	logic [sos_pkg::CFG_DATA_W-1:0]      data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

>>> src/sos_front.sv
// Front end: size registers, element loading into a free store bank, job hand-off.
module sos_front #(
	parameter int MAX_ROWS = 8,
	parameter int MAX_COLS = 8,
	localparam int DEPTH = MAX_ROWS * MAX_COLS,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	sos_item_if.sink                     item_in,
	sos_cfg_if.sink                      cfg,
	input  sos_pkg::release_t            rel,
	input  logic                         q_full,
	output logic                         push,
	output sos_pkg::job_t                push_job,
	output logic                         wr_en,
	output logic [AW:0]                  wr_addr,
	output logic [sos_pkg::VAL_W-1:0]    wr_data
);

	logic [sos_pkg::CFG_DATA_W-1:0] row_q;
	logic [sos_pkg::CFG_DATA_W-1:0] col_q;
	logic [CNT_W-1:0]               count_q;
	logic                           wr_bank_q;
	logic [1:0]                     busy_q;

	logic [sos_pkg::DIM_W-1:0]      rows;
	logic [sos_pkg::DIM_W-1:0]      cols;
	logic [2*sos_pkg::DIM_W-1:0]    total;
	logic                           accept;
	logic                           done;

	// Effective matrix size
	assign rows  = sos_pkg::clamp_dim(row_q, MAX_ROWS);
	assign cols  = sos_pkg::clamp_dim(col_q, MAX_COLS);
	assign total = (2*sos_pkg::DIM_W)'(rows) * (2*sos_pkg::DIM_W)'(cols);

	// Load only into a bank the back end has released
	assign item_in.ready = !busy_q[wr_bank_q] && !q_full;
	assign accept        = item_in.valid && item_in.ready;
	assign done          = (32'(count_q) + 32'd1) >= 32'(total);

	assign wr_en   = accept;
	assign wr_addr = {wr_bank_q, count_q[AW-1:0]};
	assign wr_data = item_in.element_value;

	assign push          = accept && done;
	assign push_job.bank = wr_bank_q;
	assign push_job.rows = rows;
	assign push_job.cols = cols;

	assign cfg.ready = 1'b1;

	// Size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= sos_pkg::CFG_DIM_RESET;
			col_q <= sos_pkg::CFG_DIM_RESET;
		end else if (cfg.valid) begin
			priority if (cfg.index == sos_pkg::CFG_ROW_COUNT) begin
				row_q <= cfg.data;
			end else if (cfg.index == sos_pkg::CFG_COLUMN_COUNT) begin
				col_q <= cfg.data;
			end
		end
	end

	// Load count, bank select and bank ownership
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			wr_bank_q <= 1'b0;
			busy_q    <= '0;
		end else begin
			if (rel.valid) begin
				busy_q[rel.bank] <= 1'b0;
			end
			if (accept) begin
				if (done) begin
					count_q           <= '0;
					wr_bank_q         <= !wr_bank_q;
					busy_q[wr_bank_q] <= 1'b1;
				end else begin
					count_q <= CNT_W'(count_q + 1'b1);
				end
			end
		end
	end

endmodule

>>> src/sos_job_fifo.sv
// Two-entry queue of loaded matrices between front and back end.
module sos_job_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sos_pkg::job_t  push_job,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output sos_pkg::job_t  head
);

	sos_pkg::job_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    fill_q;

	assign full      = (fill_q == 2'd2);
	assign not_empty = (fill_q != 2'd0);
	assign head      = entry_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   fill_q <= 2'(fill_q + 1'b1);
				2'b01:   fill_q <= 2'(fill_q - 1'b1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

>>> src/sos_back.sv
// Back end: element store, spiral walker, address stage and output register.
module sos_back #(
	parameter int MAX_ROWS = 8,
	parameter int MAX_COLS = 8,
	localparam int DEPTH = MAX_ROWS * MAX_COLS,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [AW:0]                  wr_addr,
	input  logic [sos_pkg::VAL_W-1:0]    wr_data,
	input  logic                         job_valid,
	input  sos_pkg::job_t                job,
	output logic                         pop,
	output sos_pkg::release_t            rel,
	sos_result_if.source                 result_out
);

	logic [sos_pkg::VAL_W-1:0] mem [2**(AW+1)];

	sos_pkg::walk_state_t        state_q;
	sos_pkg::walk_state_t        state_nxt;
	sos_pkg::dir_t               dir_q;
	logic [sos_pkg::COORD_W-1:0] r_q;
	logic [sos_pkg::COORD_W-1:0] c_q;
	logic [sos_pkg::COORD_W-1:0] top_q;
	logic [sos_pkg::COORD_W-1:0] bot_q;
	logic [sos_pkg::COORD_W-1:0] lft_q;
	logic [sos_pkg::COORD_W-1:0] rgt_q;
	logic [sos_pkg::REM_W-1:0]   rem_q;
	logic [sos_pkg::DIM_W-1:0]   cols_q;
	logic                        bank_q;

	logic                        valid_s1;
	logic [AW-1:0]               addr_s1;
	logic                        bank_s1;
	logic                        last_s1;
	logic                        valid_s2;
	logic                        last_s2;
	logic [sos_pkg::VAL_W-1:0]   data_s2;

	logic                        adv;
	logic                        emit;
	logic [sos_pkg::LIN_W-1:0]   lin;

	// Whole back pipeline moves when the output register is free
	assign adv = !valid_s2 || result_out.ready;
	assign lin = sos_pkg::LIN_W'(r_q) * sos_pkg::LIN_W'(cols_q) + sos_pkg::LIN_W'(c_q);

	// Walker next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			sos_pkg::WK_IDLE: if (job_valid) state_nxt = sos_pkg::WK_RUN;
			sos_pkg::WK_RUN:  if (adv && rem_q == sos_pkg::REM_W'(1)) state_nxt = sos_pkg::WK_IDLE;
			default:          state_nxt = sos_pkg::WK_IDLE;
		endcase
	end

	// Walker outputs
	always_comb begin
		pop  = 1'b0;
		emit = 1'b0;
		unique case (state_q)
			sos_pkg::WK_IDLE: pop  = job_valid;
			sos_pkg::WK_RUN:  emit = adv;
			default: begin
				pop  = 1'b0;
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sos_pkg::WK_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Spiral position and ring bounds
	always_ff @(posedge clk) begin
		if (pop) begin
			dir_q  <= sos_pkg::DIR_RIGHT;
			r_q    <= '0;
			c_q    <= '0;
			top_q  <= '0;
			lft_q  <= '0;
			bot_q  <= sos_pkg::COORD_W'(job.rows - 1'b1);
			rgt_q  <= sos_pkg::COORD_W'(job.cols - 1'b1);
			rem_q  <= sos_pkg::REM_W'(job.rows) * sos_pkg::REM_W'(job.cols);
			cols_q <= job.cols;
			bank_q <= job.bank;
		end else if (emit) begin
			rem_q <= sos_pkg::REM_W'(rem_q - 1'b1);
			unique case (dir_q)
				sos_pkg::DIR_RIGHT: begin
					if (c_q != rgt_q) begin
						c_q <= sos_pkg::COORD_W'(c_q + 1'b1);
					end else begin
						top_q <= sos_pkg::COORD_W'(top_q + 1'b1);
						r_q   <= sos_pkg::COORD_W'(r_q + 1'b1);
						dir_q <= sos_pkg::DIR_DOWN;
					end
				end
				sos_pkg::DIR_DOWN: begin
					if (r_q != bot_q) begin
						r_q <= sos_pkg::COORD_W'(r_q + 1'b1);
					end else begin
						rgt_q <= sos_pkg::COORD_W'(rgt_q - 1'b1);
						c_q   <= sos_pkg::COORD_W'(c_q - 1'b1);
						dir_q <= sos_pkg::DIR_LEFT;
					end
				end
				sos_pkg::DIR_LEFT: begin
					if (c_q != lft_q) begin
						c_q <= sos_pkg::COORD_W'(c_q - 1'b1);
					end else begin
						bot_q <= sos_pkg::COORD_W'(bot_q - 1'b1);
						r_q   <= sos_pkg::COORD_W'(r_q - 1'b1);
						dir_q <= sos_pkg::DIR_UP;
					end
				end
				sos_pkg::DIR_UP: begin
					if (r_q != top_q) begin
						r_q <= sos_pkg::COORD_W'(r_q - 1'b1);
					end else begin
						lft_q <= sos_pkg::COORD_W'(lft_q + 1'b1);
						c_q   <= sos_pkg::COORD_W'(c_q + 1'b1);
						dir_q <= sos_pkg::DIR_RIGHT;
					end
				end
				default: dir_q <= sos_pkg::DIR_RIGHT;
			endcase
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= emit;
			valid_s2 <= valid_s1;
		end
	end

	// Address stage, store write and registered store read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (adv) begin
			addr_s1 <= AW'(lin);
			bank_s1 <= bank_q;
			last_s1 <= (rem_q == sos_pkg::REM_W'(1));
			data_s2 <= mem[{bank_s1, addr_s1}];
			last_s2 <= last_s1;
		end
	end

	// Bank is free once its last element has been read
	assign rel.valid = adv && valid_s1 && last_s1;
	assign rel.bank  = bank_s1;

	assign result_out.valid     = valid_s2;
	assign result_out.out_value = data_s2;
	assign result_out.out_last  = last_s2;

endmodule

>>> src/spiral_order_scanner_core.sv
// Top level of the spiral order scanner.
// Matrix elements arrive one item per cycle in row-major order and are written
// into one of two store banks; the size comes from row_count and column_count
// (zero reads as one, values above MAX_ROWS or MAX_COLS saturate). When the
// last element of a matrix is taken, the matrix is queued and the back end
// emits it in clockwise spiral order, one result per cycle while result_out.ready
// is high, the final one with out_last set. Loading of the next matrix runs in
// the other bank during emission, and the back end picks up each queued job
// while idle before emitting it. Input stalls only while both banks hold
// matrices not yet fully read. Size writes take effect on the next element.
module spiral_order_scanner_core #(
	parameter int MAX_ROWS = 8,
	parameter int MAX_COLS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	sos_item_if.sink      item_in,
	sos_result_if.source  result_out,
	sos_cfg_if.sink       cfg
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	sos_pkg::job_t             push_job;
	sos_pkg::job_t             head;
	sos_pkg::release_t         rel;
	logic                      push;
	logic                      pop;
	logic                      q_full;
	logic                      q_not_empty;
	logic                      wr_en;
	logic [AW:0]               wr_addr;
	logic [sos_pkg::VAL_W-1:0] wr_data;

	sos_front #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_in  (item_in),
		.cfg      (cfg),
		.rel      (rel),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	sos_job_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head)
	);

	sos_back #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.job_valid  (q_not_empty),
		.job        (head),
		.pop        (pop),
		.rel        (rel),
		.result_out (result_out)
	);

endmodule
